@@ rtl/core/rsba_pkg.sv @@
package rsba_pkg;

  // Opcode group, bits 7:6
  typedef enum logic [1:0] {
    GRP_ROT = 2'd0,
    GRP_BIT = 2'd1,
    GRP_RES = 2'd2,
    GRP_SET = 2'd3
  } grp_e;

  // Rotate/shift kind, bits 5:3 of a rotate/shift opcode
  typedef enum logic [2:0] {
    SH_RLC = 3'd0,
    SH_RRC = 3'd1,
    SH_RL  = 3'd2,
    SH_RR  = 3'd3,
    SH_SLA = 3'd4,
    SH_SRA = 3'd5,
    SH_SLL = 3'd6,
    SH_SRL = 3'd7
  } shift_e;

  // Index prefix; the fourth code means nothing and reads as no prefix
  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_IX   = 2'd1,
    PFX_IY   = 2'd2
  } pfx_e;

  // Register code that names memory at (HL)
  localparam logic [2:0] REG_MEM = 3'd6;

  // Bit number of the sign bit, tested by BIT 7
  localparam logic [2:0] SEL_TOP = 3'd7;

  // Single set bit, shifted to build RES/SET masks
  localparam logic [7:0] LOW_BIT = 8'h01;

  // Flag bit positions
  localparam int unsigned FLAG_C  = 0;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_X  = 3;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_Y  = 5;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_S  = 7;

  // Decoded beat after the address stage
  typedef struct packed {
    grp_e        grp;
    logic [2:0]  sel;
    logic [2:0]  reg_idx;
    logic [7:0]  operand;
    logic [7:0]  flags_in;
    logic        to_memory;
    logic [15:0] mem_address;
  } dec_t;

  // Beat after the execute stage
  typedef struct packed {
    grp_e        grp;
    logic [2:0]  sel;
    logic [2:0]  reg_idx;
    logic [7:0]  result;
    logic        carry_out;
    logic        bit_set;
    logic [7:0]  flags_in;
    logic        to_memory;
    logic [15:0] mem_address;
  } exe_t;

  // Finished result beat
  typedef struct packed {
    logic [7:0]  result;
    logic [7:0]  flags_out;
    logic        write_enable;
    logic        to_memory;
    logic [15:0] mem_address;
    logic        reg_write;
    logic [2:0]  reg_index;
  } res_t;

endpackage

@@ rtl/core/rotate_shift_bit_alu.sv @@
// Rotate/shift/bit unit for CB-group instructions of an 8-bit processor.
// Input channel (in_valid_i/in_ready_o) carries one instruction per beat:
// opcode, index prefix, displacement, operand byte, flags and HL/IX/IY.
// Output channel (out_valid_o/out_ready_i) carries the result byte, new
// flags, write target (memory and/or register) and effective address.
// Pipeline: address stage (decode, index + displacement add), execute
// stage (rotate/shift or bit mask), flag stage (zero, parity, BIT flags),
// whose register is the output register.
// An accepted beat is registered in turn in the address, execute and flag
// stage registers. Throughput: one beat per cycle while out_ready_i holds
// high; each stage is one register with a valid.
// Reset clears all stage valids; the pipeline comes up empty and ready.
// When the receiver stalls, the output beat holds and earlier stages keep
// filling until every stage holds a beat; in_ready_o then drops. Nothing
// is dropped or repeated, and in_ready_o rises again as soon as the
// receiver takes the output beat.
module rotate_shift_bit_alu
  import rsba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  opcode_i,
  input  logic [1:0]  prefix_i,
  input  logic [7:0]  displacement_i,
  input  logic [7:0]  operand_i,
  input  logic [7:0]  flags_in_i,
  input  logic [15:0] hl_value_i,
  input  logic [15:0] ix_value_i,
  input  logic [15:0] iy_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  result_o,
  output logic [7:0]  flags_out_o,
  output logic        write_enable_o,
  output logic        to_memory_o,
  output logic [15:0] mem_address_o,
  output logic        reg_write_o,
  output logic [2:0]  reg_index_o
);

  logic dec_valid, dec_ready;
  dec_t dec_beat;
  logic exe_valid, exe_ready;
  exe_t exe_beat;
  res_t res_beat;

  // Stage 1: decode and effective address
  rsba_addr_stage u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .opcode_i       (opcode_i),
    .prefix_i       (prefix_i),
    .displacement_i (displacement_i),
    .operand_i      (operand_i),
    .flags_in_i     (flags_in_i),
    .hl_value_i     (hl_value_i),
    .ix_value_i     (ix_value_i),
    .iy_value_i     (iy_value_i),
    .valid_o        (dec_valid),
    .ready_i        (dec_ready),
    .beat_o         (dec_beat)
  );

  // Stage 2: byte operation
  rsba_exec_stage u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .beat_i  (dec_beat),
    .valid_o (exe_valid),
    .ready_i (exe_ready),
    .beat_o  (exe_beat)
  );

  // Stage 3: flags and output register
  rsba_flag_stage u_flag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exe_valid),
    .ready_o (exe_ready),
    .beat_i  (exe_beat),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .beat_o  (res_beat)
  );

  assign result_o       = res_beat.result;
  assign flags_out_o    = res_beat.flags_out;
  assign write_enable_o = res_beat.write_enable;
  assign to_memory_o    = res_beat.to_memory;
  assign mem_address_o  = res_beat.mem_address;
  assign reg_write_o    = res_beat.reg_write;
  assign reg_index_o    = res_beat.reg_index;

  // Input backpressure only when the whole pipe is full and stalled
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && dec_valid && exe_valid))
    else $error("input stalled while a stage is free");

  // A register copy never targets the memory code and needs a write
  a_reg_write_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reg_write_o) |-> (write_enable_o && reg_index_o != REG_MEM))
    else $error("register write with bad target");

  // BIT beats set H, clear N and leave the byte unwritten
  a_bit_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |->
      (flags_out_o[FLAG_H] && !flags_out_o[FLAG_N] && !reg_write_o))
    else $error("BIT beat with wrong flags");

  // With the receiver ready, an accepted beat moves from the address stage
  // register into the execute stage register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_ready_i && $past(out_ready_i, 1) == 1'b1)
      ##0 (1'b1) |=> ##1 (exe_valid || !out_ready_i || !$past(out_ready_i)))
    else $error("beat lost in pipeline");

endmodule

@@ rtl/core/rsba_addr_stage.sv @@
module rsba_addr_stage
  import rsba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  opcode_i,
  input  logic [1:0]  prefix_i,
  input  logic [7:0]  displacement_i,
  input  logic [7:0]  operand_i,
  input  logic [7:0]  flags_in_i,
  input  logic [15:0] hl_value_i,
  input  logic [15:0] ix_value_i,
  input  logic [15:0] iy_value_i,
  output logic        valid_o,
  input  logic        ready_i,
  output dec_t        beat_o
);

  logic        valid_q;
  dec_t        beat_d, beat_q;
  logic [15:0] disp_ext;
  logic        indexed;

  // Sign-extend the displacement to address width
  assign disp_ext = {{8{displacement_i[7]}}, displacement_i};

  // Decode fields and form the effective address
  always_comb begin
    beat_d          = '0;
    beat_d.grp      = grp_e'(opcode_i[7:6]);
    beat_d.sel      = opcode_i[5:3];
    beat_d.reg_idx  = opcode_i[2:0];
    beat_d.operand  = operand_i;
    beat_d.flags_in = flags_in_i;
    indexed         = 1'b0;
    unique case (prefix_i)
      PFX_IX: begin
        indexed            = 1'b1;
        beat_d.mem_address = ix_value_i + disp_ext;
      end
      PFX_IY: begin
        indexed            = 1'b1;
        beat_d.mem_address = iy_value_i + disp_ext;
      end
      default: begin
        beat_d.mem_address = hl_value_i;
      end
    endcase
    beat_d.to_memory = indexed || (opcode_i[2:0] == REG_MEM);
  end

  // Advance when empty or when the next stage takes the held beat
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

endmodule

@@ rtl/core/rsba_exec_stage.sv @@
module rsba_exec_stage
  import rsba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t beat_i,
  output logic valid_o,
  input  logic ready_i,
  output exe_t beat_o
);

  logic       valid_q;
  exe_t       beat_d, beat_q;
  logic [7:0] val;
  logic       cin;
  logic [7:0] mask;

  assign val  = beat_i.operand;
  assign cin  = beat_i.flags_in[FLAG_C];
  assign mask = LOW_BIT << beat_i.sel;

  // Rotate, shift, test, reset or set the operand byte
  always_comb begin
    beat_d             = '0;
    beat_d.grp         = beat_i.grp;
    beat_d.sel         = beat_i.sel;
    beat_d.reg_idx     = beat_i.reg_idx;
    beat_d.flags_in    = beat_i.flags_in;
    beat_d.to_memory   = beat_i.to_memory;
    beat_d.mem_address = beat_i.mem_address;
    beat_d.result      = val;
    beat_d.bit_set     = |(val & mask);
    unique case (beat_i.grp)
      GRP_ROT: begin
        unique case (shift_e'(beat_i.sel))
          SH_RLC: begin
            beat_d.result = {val[6:0], val[7]}; beat_d.carry_out = val[7];
          end
          SH_RRC: begin
            beat_d.result = {val[0], val[7:1]}; beat_d.carry_out = val[0];
          end
          SH_RL: begin
            beat_d.result = {val[6:0], cin}; beat_d.carry_out = val[7];
          end
          SH_RR: begin
            beat_d.result = {cin, val[7:1]}; beat_d.carry_out = val[0];
          end
          SH_SLA: begin
            beat_d.result = {val[6:0], 1'b0}; beat_d.carry_out = val[7];
          end
          SH_SRA: begin
            beat_d.result = {val[7], val[7:1]}; beat_d.carry_out = val[0];
          end
          SH_SLL: begin
            beat_d.result = {val[6:0], 1'b1}; beat_d.carry_out = val[7];
          end
          SH_SRL: begin
            beat_d.result = {1'b0, val[7:1]}; beat_d.carry_out = val[0];
          end
          default: begin
            beat_d.result = val;
          end
        endcase
      end
      GRP_RES: beat_d.result = val & ~mask;
      GRP_SET: beat_d.result = val | mask;
      default: beat_d.result = val;
    endcase
  end

  // Advance when empty or when the next stage takes the held beat
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

endmodule

@@ rtl/core/rsba_flag_stage.sv @@
module rsba_flag_stage
  import rsba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  exe_t beat_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t beat_o
);

  logic       valid_q;
  res_t       beat_d, beat_q;
  logic [7:0] res;
  logic [7:0] f;
  logic       we;

  assign res = beat_i.result;
  assign we  = (beat_i.grp != GRP_BIT);

  // Build the new flag byte for the group
  always_comb begin
    f = '0;
    unique case (beat_i.grp)
      GRP_ROT: begin
        f[FLAG_S]  = res[7];
        f[FLAG_Z]  = (res == 8'h00);
        f[FLAG_Y]  = res[5];
        f[FLAG_X]  = res[3];
        f[FLAG_PV] = ~^res;
        f[FLAG_C]  = beat_i.carry_out;
      end
      GRP_BIT: begin
        f[FLAG_S]  = beat_i.bit_set && (beat_i.sel == SEL_TOP);
        f[FLAG_Z]  = !beat_i.bit_set;
        f[FLAG_H]  = 1'b1;
        f[FLAG_PV] = !beat_i.bit_set;
        f[FLAG_C]  = beat_i.flags_in[FLAG_C];
      end
      default: begin
        f = beat_i.flags_in;
      end
    endcase
  end

  // Assemble the result beat and its write target
  always_comb begin
    beat_d              = '0;
    beat_d.result       = res;
    beat_d.flags_out    = f;
    beat_d.write_enable = we;
    beat_d.to_memory    = beat_i.to_memory;
    beat_d.mem_address  = beat_i.mem_address;
    beat_d.reg_write    = we && (beat_i.reg_idx != REG_MEM);
    beat_d.reg_index    = beat_i.reg_idx;
  end

  // Output register: hold the beat until the receiver takes it
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import rsba_pkg::*;

  // Register codes used by the directed beats
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_A = 3'd7;

  // Prefix code that has no meaning and reads as no prefix
  localparam logic [1:0] PFX_UNUSED = 2'd3;

  // One CB-group instruction as offered on the input channel
  typedef struct packed {
    logic [7:0]  opcode;
    logic [1:0]  prefix;
    logic [7:0]  disp;
    logic [7:0]  operand;
    logic [7:0]  flags;
    logic [15:0] hl;
    logic [15:0] ix;
    logic [15:0] iy;
  } cb_item_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  opcode       = '0;
  logic [1:0]  prefix       = '0;
  logic [7:0]  displacement = '0;
  logic [7:0]  operand      = '0;
  logic [7:0]  flags_in     = '0;
  logic [15:0] hl_value     = '0;
  logic [15:0] ix_value     = '0;
  logic [15:0] iy_value     = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  result;
  logic [7:0]  flags_out;
  logic        write_enable;
  logic        to_memory;
  logic [15:0] mem_address;
  logic        reg_write;
  logic [2:0]  reg_index;

  bit   source_idle_on = 1'b1;
  bit   sink_idle_on   = 1'b1;
  int   mismatches     = 0;
  res_t cb_result_q[$];

  rotate_shift_bit_alu u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .prefix_i       (prefix),
    .displacement_i (displacement),
    .operand_i      (operand),
    .flags_in_i     (flags_in),
    .hl_value_i     (hl_value),
    .ix_value_i     (ix_value),
    .iy_value_i     (iy_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_o       (result),
    .flags_out_o    (flags_out),
    .write_enable_o (write_enable),
    .to_memory_o    (to_memory),
    .mem_address_o  (mem_address),
    .reg_write_o    (reg_write),
    .reg_index_o    (reg_index)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Compute the result beat one instruction must produce
  function automatic res_t cb_execute(input cb_item_t it);
    res_t       r;
    grp_e       grp;
    logic [2:0] sel;
    logic [2:0] rix;
    logic [7:0] v;
    logic [7:0] res;
    logic [7:0] f;
    logic       cin;
    logic       cout;
    grp  = grp_e'(it.opcode[7:6]);
    sel  = it.opcode[5:3];
    rix  = it.opcode[2:0];
    v    = it.operand;
    cin  = it.flags[FLAG_C];
    cout = 1'b0;
    res  = v;
    f    = it.flags;
    case (grp)
      GRP_ROT: begin
        case (shift_e'(sel))
          SH_RLC:  begin res = {v[6:0], v[7]}; cout = v[7]; end
          SH_RRC:  begin res = {v[0], v[7:1]}; cout = v[0]; end
          SH_RL:   begin res = {v[6:0], cin};  cout = v[7]; end
          SH_RR:   begin res = {cin, v[7:1]};  cout = v[0]; end
          SH_SLA:  begin res = {v[6:0], 1'b0}; cout = v[7]; end
          SH_SRA:  begin res = {v[7], v[7:1]}; cout = v[0]; end
          SH_SLL:  begin res = {v[6:0], 1'b1}; cout = v[7]; end
          default: begin res = {1'b0, v[7:1]}; cout = v[0]; end
        endcase
        f           = '0;
        f[FLAG_S]   = res[7];
        f[FLAG_Y]   = res[5];
        f[FLAG_X]   = res[3];
        f[FLAG_Z]   = (res == 8'h00);
        f[FLAG_PV]  = ~^res;
        f[FLAG_C]   = cout;
      end
      GRP_BIT: begin
        f         = '0;
        f[FLAG_C] = cin;
        f[FLAG_H] = 1'b1;
        // S only reports the sign bit, Z and PV report a clear bit
        if (v[sel]) begin
          f[FLAG_S] = (sel == SEL_TOP);
        end else begin
          f[FLAG_Z]  = 1'b1;
          f[FLAG_PV] = 1'b1;
        end
      end
      GRP_RES: res = v & ~(LOW_BIT << sel);
      default: res = v | (LOW_BIT << sel);
    endcase
    case (it.prefix)
      PFX_IX:  r.mem_address = it.ix + {{8{it.disp[7]}}, it.disp};
      PFX_IY:  r.mem_address = it.iy + {{8{it.disp[7]}}, it.disp};
      default: r.mem_address = it.hl;
    endcase
    r.result       = res;
    r.flags_out    = f;
    r.write_enable = (grp != GRP_BIT);
    r.to_memory    = (it.prefix == PFX_IX) || (it.prefix == PFX_IY) || (rix == REG_MEM);
    r.reg_write    = (grp != GRP_BIT) && (rix != REG_MEM);
    r.reg_index    = rix;
    return r;
  endfunction

  function automatic cb_item_t cb_item(input logic [7:0] op, input logic [1:0] pfx,
                                       input logic [7:0] disp, input logic [7:0] val,
                                       input logic [7:0] fl, input logic [15:0] hl,
                                       input logic [15:0] ix, input logic [15:0] iy);
    cb_item_t it;
    it = '{op, pfx, disp, val, fl, hl, ix, iy};
    return it;
  endfunction

  // Random instruction, biased toward edge values of the displacement, operand and index fields
  function automatic cb_item_t rand_item();
    cb_item_t it;
    int       pick;
    it.opcode = 8'($urandom_range(255));
    pick      = $urandom_range(99);
    it.prefix = (pick < 40) ? PFX_NONE : (pick < 68) ? PFX_IX : (pick < 96) ? PFX_IY
                : PFX_UNUSED;
    if ($urandom_range(9) == 0) begin
      it.disp = $urandom_range(1) ? 8'h80 : 8'h7F;
    end else begin
      it.disp = 8'($urandom_range(255));
    end
    pick = $urandom_range(15);
    case (pick)
      0:       it.operand = 8'h00;
      1:       it.operand = 8'hFF;
      2:       it.operand = LOW_BIT << $urandom_range(7);
      default: it.operand = 8'($urandom_range(255));
    endcase
    it.flags = 8'($urandom_range(255));
    it.hl    = 16'($urandom_range(16'hFFFF));
    it.ix    = $urandom_range(7) == 0 ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
    it.iy    = $urandom_range(7) == 0 ? 16'h0000 : 16'($urandom_range(16'hFFFF));
    return it;
  endfunction

  // Offer one beat, then hold it until accepted; valid stays up afterwards
  task automatic send_cb(input cb_item_t it);
    if (source_idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= it.opcode;
    prefix       <= it.prefix;
    displacement <= it.disp;
    operand      <= it.operand;
    flags_in     <= it.flags;
    hl_value     <= it.hl;
    ix_value     <= it.ix;
    iy_value     <= it.iy;
    do @(posedge clk); while (!in_ready);
    cb_result_q.push_back(cb_execute(it));
  endtask

  // Drop valid and wait until every expected beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cb_result_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_rotate_shift();
    for (int k = 0; k < 8; k++) begin
      send_cb(cb_item({GRP_ROT, 3'(k), REG_A}, PFX_NONE, 8'h00, 8'h81, {7'h7F, k[0]},
                      16'h1234, 16'h0000, 16'h0000));
    end
    // shifts that leave zero behind
    send_cb(cb_item({GRP_ROT, SH_SLA, REG_B}, PFX_NONE, 8'h00, 8'h80, 8'hFF,
                    16'h0000, 16'h0000, 16'h0000));
    send_cb(cb_item({GRP_ROT, SH_SRL, REG_B}, PFX_NONE, 8'h00, 8'h01, 8'hFF,
                    16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_bit_test();
    send_cb(cb_item({GRP_BIT, SEL_TOP, REG_A}, PFX_NONE, 8'h00, 8'h80, 8'h00,
                    16'h0000, 16'h0000, 16'h0000));
    send_cb(cb_item({GRP_BIT, SEL_TOP, REG_A}, PFX_NONE, 8'h00, 8'h7F, 8'hFF,
                    16'h0000, 16'h0000, 16'h0000));
    send_cb(cb_item({GRP_BIT, 3'd0, REG_B}, PFX_NONE, 8'h00, 8'hFE, 8'h01,
                    16'h0000, 16'h0000, 16'h0000));
    // a set bit other than the sign bit leaves S clear
    send_cb(cb_item({GRP_BIT, 3'd3, REG_B}, PFX_NONE, 8'h00, 8'hFF, 8'hFF,
                    16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_res_set();
    send_cb(cb_item({GRP_RES, 3'd7, REG_A}, PFX_NONE, 8'h00, 8'hFF, 8'h00,
                    16'h0000, 16'h0000, 16'h0000));
    send_cb(cb_item({GRP_SET, 3'd0, REG_A}, PFX_NONE, 8'h00, 8'h00, 8'hFF,
                    16'h0000, 16'h0000, 16'h0000));
    send_cb(cb_item({GRP_RES, 3'd0, REG_B}, PFX_NONE, 8'h00, 8'h00, 8'h55,
                    16'h0000, 16'h0000, 16'h0000));
    send_cb(cb_item({GRP_SET, 3'd7, REG_B}, PFX_NONE, 8'h00, 8'hFF, 8'hAA,
                    16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_addressing();
    send_cb(cb_item({GRP_ROT, SH_RLC, REG_MEM}, PFX_NONE, 8'h7F, 8'h3C, 8'h00,
                    16'hFFFF, 16'h1111, 16'h2222));
    // index plus displacement wraps in both directions
    send_cb(cb_item({GRP_ROT, SH_RR, REG_MEM}, PFX_IX, 8'h80, 8'h01, 8'h01,
                    16'h4444, 16'h0000, 16'h2222));
    send_cb(cb_item({GRP_SET, 3'd7, REG_MEM}, PFX_IY, 8'h7F, 8'h00, 8'h00,
                    16'h4444, 16'h1111, 16'hFFFF));
    // register form under a prefix writes memory and the register
    send_cb(cb_item({GRP_RES, 3'd3, REG_B}, PFX_IX, 8'hFE, 8'hFF, 8'h00,
                    16'h4444, 16'h8000, 16'h2222));
    send_cb(cb_item({GRP_BIT, 3'd5, REG_D}, PFX_IY, 8'h10, 8'h20, 8'h01,
                    16'h4444, 16'h1111, 16'h7FF8));
    send_cb(cb_item({GRP_ROT, SH_SRA, REG_MEM}, PFX_UNUSED, 8'h80, 8'h80, 8'h00,
                    16'hABCD, 16'h1111, 16'h2222));
  endtask

  task automatic test_random_stream(input int count);
    for (int n = 0; n < count; n++) begin
      // hold off once until the pipeline is empty
      if (n == count / 2) wait_drained();
      send_cb(rand_item());
    end
  endtask

  task automatic test_back_to_back(input int count);
    source_idle_on = 1'b0;
    sink_idle_on   = 1'b0;
    for (int n = 0; n < count; n++) send_cb(rand_item());
    source_idle_on = 1'b1;
    sink_idle_on   = 1'b1;
  endtask

  // Stall the result channel at random while sink idling is on
  always @(posedge clk) begin
    out_ready <= !sink_idle_on || ($urandom_range(99) >= 36);
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cb_result_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, result);
        mismatches++;
      end else begin
        want = cb_result_q.pop_front();
        check_field("result", 16'(want.result), 16'(result));
        check_field("flags_out", 16'(want.flags_out), 16'(flags_out));
        check_field("write_enable", 16'(want.write_enable), 16'(write_enable));
        check_field("to_memory", 16'(want.to_memory), 16'(to_memory));
        check_field("mem_address", want.mem_address, mem_address);
        check_field("reg_write", 16'(want.reg_write), 16'(reg_write));
        check_field("reg_index", 16'(want.reg_index), 16'(reg_index));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_rotate_shift();
    test_bit_test();
    test_res_set();
    test_addressing();
    test_random_stream(600);
    test_back_to_back(150);
    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
